/* design/spm_pkg.sv */
// Shared types and codes for the stable priority mailbox.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int PRIO_WIDTH_DEFAULT = 8;
    localparam int OCC_W              = 5;
    localparam int REQ_PRIO_W         = 8;
    localparam int DATA_W             = 32;

    // Request codes.
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_POP    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [REQ_PRIO_W-1:0]    priority_req;
        logic signed [DATA_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] popped_payload;
        logic [OCC_W-1:0]         occupancy;
    } t_rsp;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* design/spm_cell.sv */
// One storage cell of the sorted chain: holds one entry, shifts left or right.
`timescale 1ns / 1ps
`default_nettype none
module spm_cell
    import spm_pkg::*;
#(
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic                    i_occupied,
    input  wire logic [PRIO_WIDTH-1:0]   i_new_prio,
    input  wire logic [DATA_W-1:0]       i_new_data,
    input  wire logic                    i_left_keep,
    input  wire logic [PRIO_WIDTH-1:0]   i_left_prio,
    input  wire logic [DATA_W-1:0]       i_left_data,
    input  wire logic [PRIO_WIDTH-1:0]   i_right_prio,
    input  wire logic [DATA_W-1:0]       i_right_data,
    output logic                         o_keep,
    output logic [PRIO_WIDTH-1:0]        o_prio,
    output logic [DATA_W-1:0]            o_data
);

    logic [PRIO_WIDTH-1:0] r_prio, n_prio;
    logic [DATA_W-1:0]     r_data, n_data;

    // An occupied entry with a number lower or equal stays ahead of the new one.
    assign o_keep = i_occupied && (r_prio <= i_new_prio);

    always_comb begin
        n_prio = r_prio;
        n_data = r_data;
        if (i_ctl.ins && !o_keep) begin
            if (i_left_keep) begin
                n_prio = i_new_prio;
                n_data = i_new_data;
            end else begin
                n_prio = i_left_prio;
                n_data = i_left_data;
            end
        end else if (i_ctl.pop) begin
            n_prio = i_right_prio;
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_prio = r_prio;
    assign o_data = r_data;

endmodule
`default_nettype wire

/* design/stable_priority_mailbox_top.sv */
// Top level of the stable priority mailbox: request decode, entry count and cell chain.
`timescale 1ns / 1ps
`default_nettype none
// The mailbox keeps up to DEPTH entries sorted by ascending priority number,
// first-in first-out among equal numbers, in a row of cells that each compare
// their own entry against the incoming priority and shift together. Every
// request (insert, pop, clear) produces one response word in the output
// register on the following cycle. A new request word is taken whenever the
// output register is empty or its word is being taken in the same cycle, so
// with a ready consumer one request is served per clock.
// Nothing needs clearing after reset; the store is usable at once.
module stable_priority_mailbox_top
    import spm_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int PRIO_WIDTH = PRIO_WIDTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_word,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    t_rsp          r_out, n_out;
    t_cell_ctl     w_ctl;
    logic          w_acc, w_full, w_empty;

    logic [PRIO_WIDTH-1:0]            w_new_prio;
    logic [PRIO_WIDTH+REQ_PRIO_W-1:0] w_prio_ext;
    logic [CW+OCC_W-1:0]              w_occ_ext;

    logic [PRIO_WIDTH-1:0] w_prio [DEPTH];
    logic [DATA_W-1:0]     w_data [DEPTH];
    logic                  w_keep [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Priority is kept in PRIO_WIDTH bits: zero-extend, then take the low part.
    assign w_prio_ext = {{PRIO_WIDTH{1'b0}}, i_in_word.priority_req};
    assign w_new_prio = w_prio_ext[PRIO_WIDTH-1:0];

    always_comb begin
        w_ctl                = '0;
        n_count              = r_count;
        n_out.status         = ST_OK;
        n_out.popped_payload = '0;
        unique case (i_in_word.req_type)
            REQ_INSERT: begin
                if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_ctl.ins = w_acc;
                    n_count   = r_count + CW'(1);
                end
            end
            REQ_POP: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    w_ctl.pop            = w_acc;
                    n_out.popped_payload = w_data[0];
                    n_count              = r_count - CW'(1);
                end
            end
            REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        w_occ_ext       = {{OCC_W{1'b0}}, n_count};
        n_out.occupancy = w_occ_ext[OCC_W-1:0];
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  w_left_keep;
        logic [PRIO_WIDTH-1:0] w_left_prio, w_right_prio;
        logic [DATA_W-1:0]     w_left_data, w_right_data;

        if (g == 0) begin : g_head
            // The head has nothing ahead of it; a new entry lands here first.
            assign w_left_keep = 1'b1;
            assign w_left_prio = w_new_prio;
            assign w_left_data = i_in_word.payload;
        end else begin : g_body
            assign w_left_keep = w_keep[g-1];
            assign w_left_prio = w_prio[g-1];
            assign w_left_data = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_prio = w_prio[g];
            assign w_right_data = w_data[g];
        end else begin : g_inner
            assign w_right_prio = w_prio[g+1];
            assign w_right_data = w_data[g+1];
        end

        spm_cell #(
            .PRIO_WIDTH(PRIO_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occupied  (CW'(g) < r_count),
            .i_new_prio  (w_new_prio),
            .i_new_data  (i_in_word.payload),
            .i_left_keep (w_left_keep),
            .i_left_prio (w_left_prio),
            .i_left_data (w_left_data),
            .i_right_prio(w_right_prio),
            .i_right_data(w_right_data),
            .o_keep      (w_keep[g]),
            .o_prio      (w_prio[g]),
            .o_data      (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_word.req_type == REQ_INSERT) && !w_full
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the store");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_word.req_type == REQ_CLEAR) |=> r_count == '0)
        else $error("clear left entries behind");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_EMPTY) |-> r_out.popped_payload == '0)
        else $error("empty pop returned data");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && (i_in_word.req_type == REQ_POP) && !w_empty
        |=> r_count == $past(r_count) - CW'(1))
        else $error("pop did not shrink the store");
`endif

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the stable priority mailbox with a small scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import spm_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out_word;

    // Long stretches with no idling are switched on per chunk of the random part.
    bit quiet = 1'b0;

    stable_priority_mailbox_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    // Keeps its own sorted copy of the store and the responses still owed.
    class mailbox_scoreboard;
        typedef struct packed {
            logic [PRIO_WIDTH_DEFAULT-1:0] prio;
            logic signed [DATA_W-1:0]      data;
        } t_entry;

        t_entry stored[$];
        t_rsp   owed[$];
        int     errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_request(t_req w);
            t_entry e;
            t_rsp   rsp;
            int     pos;
            rsp = '0;
            rsp.status = ST_OK;
            case (w.req_type)
                REQ_INSERT: begin
                    if (stored.size() >= DEPTH_DEFAULT) begin
                        rsp.status = ST_FULL;
                    end else begin
                        e.prio = w.priority_req[PRIO_WIDTH_DEFAULT-1:0];
                        e.data = w.payload;
                        // New entry goes behind every entry of lower or equal number.
                        pos = 0;
                        while (pos < stored.size() && stored[pos].prio <= e.prio)
                            pos++;
                        stored.insert(pos, e);
                    end
                end
                REQ_POP: begin
                    if (stored.size() == 0) begin
                        rsp.status = ST_EMPTY;
                    end else begin
                        e = stored.pop_front();
                        rsp.popped_payload = e.data;
                    end
                end
                REQ_CLEAR: begin
                    stored.delete();
                end
                default: begin
                end
            endcase
            rsp.occupancy = OCC_W'(stored.size());
            owed.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp exp_rsp;
            if (owed.size() == 0) begin
                $error("response word with nothing outstanding: status %0d payload %0d occ %0d",
                       got.status, got.popped_payload, got.occupancy);
                errors++;
                return;
            end
            exp_rsp = owed.pop_front();
            if (got.status !== exp_rsp.status) begin
                $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
                errors++;
            end
            if (got.popped_payload !== exp_rsp.popped_payload) begin
                $error("popped_payload: expected %0d, got %0d",
                       exp_rsp.popped_payload, got.popped_payload);
                errors++;
            end
            if (got.occupancy !== exp_rsp.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_rsp.occupancy, got.occupancy);
                errors++;
            end
        endfunction
    endclass

    mailbox_scoreboard sb;

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_request(input t_req w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(w);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [7:0] prio,
                               input logic signed [31:0] data);
        t_req w;
        w.req_type     = op;
        w.priority_req = prio;
        w.payload      = data;
        send_request(w);
    endtask

    // Consumer side: ready runs of random length broken by stalls.
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_response(o_out_word);
    end

    initial begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        int issued;
        int insert_pct;
        int prio_mode;
        int r;
        logic [1:0] op;
        logic [7:0] prio;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty pop, extremes, equal numbers, unused code, clear, full.
        send_fields(REQ_POP, 8'd0, 32'sd0);
        send_fields(REQ_INSERT, 8'd255, 32'sh7FFF_FFFF);
        send_fields(REQ_INSERT, 8'd0, 32'sh8000_0000);
        send_fields(REQ_INSERT, 8'd255, -32'sd1);
        send_fields(REQ_UNUSED, 8'hA5, 32'sh5A5A_5A5A);
        send_fields(REQ_POP, 8'hFF, -32'sd1);
        send_fields(REQ_CLEAR, 8'h00, 32'sd0);
        send_fields(REQ_POP, 8'd0, 32'sd0);
        for (int k = 0; k < DEPTH_DEFAULT; k++)
            send_fields(REQ_INSERT, 8'(k % 3), 32'(k + 1));
        send_fields(REQ_INSERT, 8'd0, 32'sd99);

        // Random part in chunks, each with its own mix and pacing.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            insert_pct = $urandom_range(20, 80);
            prio_mode  = $urandom_range(0, 2);
            quiet      = ($urandom_range(0, 4) == 0);
            for (int k = 0; k < 50; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = REQ_CLEAR;
                else if (r < 5)
                    op = REQ_UNUSED;
                else if (r < 5 + insert_pct * 95 / 100)
                    op = REQ_INSERT;
                else
                    op = REQ_POP;
                case (prio_mode)
                    0: prio = 8'($urandom_range(0, 3));
                    1: prio = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 255));
                    default: prio = 8'($urandom);
                endcase
                send_fields(op, prio, $urandom);
                if (op != REQ_UNUSED)
                    issued++;
            end
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
design/spm_pkg.sv
design/spm_cell.sv
design/stable_priority_mailbox_top.sv
tb/testbench.sv
